[sv/grp_pkg.sv]
// ----------------------------------------------------------------------------
// grp_pkg
// Types and constants shared by the gyro rate PI axis block: transaction
// payloads, configuration set, serial unit handshakes and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package grp_pkg;

   // serial multiplier: multiplicand, multiplier and product widths
   localparam int MUL_A_W   = 33;
   localparam int MUL_B_W   = 16;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W = $clog2(MUL_B_W);

   // serial divider: dividend and divisor widths
   localparam int DIV_N_W   = 33;
   localparam int DIV_D_W   = 16;
   localparam int DIV_CNT_W = $clog2(DIV_N_W);

   // fixed-point constants of the loop
   localparam logic [MUL_B_W-1:0] PERIOD_RECIP = 16'd18793;  // round(2^26 / 3571)
   localparam int PERIOD_FRAC = 26;
   localparam int I_SHIFT     = 5;
   localparam int TRIM_SHIFT  = 6;
   localparam int OUT_SHIFT   = 6;

   localparam int CSR_DATA_W  = 24;

   localparam logic KIND_SAMPLE  = 1'b0;
   localparam logic KIND_COMPUTE = 1'b1;

   typedef enum logic [2:0] {
      CSR_STICK_RATE      = 3'd0,
      CSR_FILTER_DIVISOR  = 3'd1,
      CSR_PROP_GAIN       = 3'd2,
      CSR_INTEG_GAIN      = 3'd3,
      CSR_ACCUM_LIMIT     = 3'd4,
      CSR_INTEG_OUT_LIMIT = 3'd5,
      CSR_TRIM_OFFSET     = 3'd6
   } grp_csr_type;

   typedef struct packed {
      logic               kind;
      logic signed [15:0] gyro_sample;
      logic signed [15:0] stick_value;
      logic [15:0]        loop_period;
   } grp_req_type;

   typedef struct packed {
      logic signed [15:0] drive_value;
      logic               integ_limited;
   } grp_rsp_type;

   typedef struct packed {
      logic [2:0]        stick_rate;
      logic [7:0]        filter_divisor;
      logic signed [7:0] prop_gain;
      logic signed [7:0] integ_gain;
      logic [23:0]       accum_limit;
      logic [19:0]       integ_out_limit;
      logic signed [7:0] trim_offset;
   } grp_cfg_type;

   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] mcand;
      logic [MUL_B_W-1:0] mplier;
   } grp_mul_req_type;

   typedef struct packed {
      logic               done;
      logic [MUL_P_W-1:0] product;
   } grp_mul_rsp_type;

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
   } grp_div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_N_W-1:0] quotient;
   } grp_div_rsp_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_F_MUL,
      S_F_MULW,
      S_F_ADD,
      S_F_DIV,
      S_F_DIVW,
      S_R_MUL1,
      S_R_MUL1W,
      S_R_MUL2,
      S_R_MUL2W,
      S_INTEG,
      S_A_DIV,
      S_A_DIVW,
      S_P_MUL,
      S_P_MULW,
      S_P_SUM,
      S_I_MUL,
      S_I_MULW,
      S_I_CLAMP,
      S_TOTAL
   } grp_state_type;

endpackage

`default_nettype wire

[sv/grp_serial_mul.sv]
// ----------------------------------------------------------------------------
// grp_serial_mul
// Unsigned shift-add multiplier, one multiplier bit per cycle, LSB first.
// The adder is only as wide as the multiplicand.
// ----------------------------------------------------------------------------
`default_nettype none

module grp_serial_mul (
   input  logic                     clock,
   input  logic                     reset,
   input  grp_pkg::grp_mul_req_type mul_req,
   output grp_pkg::grp_mul_rsp_type mul_rsp
);
   import grp_pkg::*;

   logic [MUL_A_W-1:0]   mcand_ff, mcand_in;
   logic [MUL_P_W-1:0]   acc_ff, acc_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MUL_A_W:0]     part_sum;
   logic                 last;

   assign last     = (cnt_ff == MUL_CNT_W'(MUL_B_W - 1));
   assign part_sum = {1'b0, acc_ff[MUL_P_W-1:MUL_B_W]}
                   + (acc_ff[0] ? {1'b0, mcand_ff} : {(MUL_A_W+1){1'b0}});

   always_comb begin
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      mcand_in = mcand_ff;
      acc_in   = acc_ff;
      done_in  = busy_ff & last;
      if (mul_req.start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         mcand_in = mul_req.mcand;
         acc_in   = {{MUL_A_W{1'b0}}, mul_req.mplier};
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         acc_in = {part_sum, acc_ff[MUL_B_W-1:1]};
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      acc_ff   <= acc_in;
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = acc_ff;

endmodule

`default_nettype wire

[sv/grp_serial_div.sv]
// ----------------------------------------------------------------------------
// grp_serial_div
// Unsigned restoring divider, one quotient bit per cycle, MSB first.
// Shared by the gyro filter and the sample average.
// ----------------------------------------------------------------------------
`default_nettype none

module grp_serial_div (
   input  logic                     clock,
   input  logic                     reset,
   input  grp_pkg::grp_div_req_type div_req,
   output grp_pkg::grp_div_rsp_type div_rsp
);
   import grp_pkg::*;

   logic [DIV_D_W-1:0]   rem_ff, rem_in;
   logic [DIV_N_W-1:0]   quo_ff, quo_in;
   logic [DIV_D_W-1:0]   dsor_ff, dsor_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_D_W:0]     shifted;
   logic [DIV_D_W+1:0]   diff;
   logic                 fits;
   logic                 last;

   assign last    = (cnt_ff == DIV_CNT_W'(DIV_N_W - 1));
   assign shifted = {rem_ff, quo_ff[DIV_N_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dsor_ff};
   assign fits    = ~diff[DIV_D_W+1];

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsor_in = dsor_ff;
      done_in = busy_ff & last;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dsor_in = div_req.divisor;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         rem_in = fits ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
         quo_in = {quo_ff[DIV_N_W-2:0], fits};
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dsor_ff <= dsor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

`default_nettype wire

[sv/grp_ctrl.sv]
// ----------------------------------------------------------------------------
// grp_ctrl
// Sequencer and loop state of the rate PI axis: filter, period scaling,
// integrator, gyro averaging and output sum, driving the serial multiplier
// and divider in turn.
// ----------------------------------------------------------------------------
`default_nettype none

module grp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  grp_pkg::grp_cfg_type cfg,
   input  logic                 req_take,
   input  grp_pkg::grp_req_type req_item,
   input  logic                 res_free,
   output logic                 busy,
   output logic                 res_load,
   output grp_pkg::grp_rsp_type res_item
);
   import grp_pkg::*;

   grp_state_type   state_ff, state_in;
   grp_mul_req_type mul_req;
   grp_mul_rsp_type mul_rsp;
   grp_div_req_type div_req;
   grp_div_rsp_type div_rsp;

   logic signed [15:0] gyro_ff, gyro_in;
   logic signed [16:0] stick_ff, stick_in;
   logic [15:0]        period_ff, period_in;
   logic signed [23:0] smooth_ff, smooth_in;
   logic signed [24:0] integ_ff, integ_in;
   logic signed [31:0] sum_ff, sum_in;
   logic [15:0]        count_ff, count_in;
   logic               sign_ff, sign_in;
   logic [32:0]        work_ff, work_in;
   logic signed [26:0] pterm_ff, pterm_in;
   logic signed [20:0] iterm_ff, iterm_in;
   logic               hit_ff, hit_in;

   // stick scaling
   logic signed [16:0] stick_ext;
   logic signed [16:0] stick_asr;
   logic [2:0]         stick_sh;
   logic signed [16:0] stick_scaled;
   logic               filter_on;

   // filter combine
   logic signed [32:0] fprod;
   logic signed [32:0] fsum;
   logic [32:0]        fsum_mag;
   logic [23:0]        fquo;

   // gyro integer and rate error
   logic signed [23:0] smooth_bias;
   logic signed [15:0] gyro_int;
   logic signed [17:0] rate_err;
   logic [17:0]        rate_neg;
   logic [23:0]        smooth_mag;

   // integrator update
   logic [21:0]        x_mag;
   logic signed [25:0] x_val;
   logic signed [25:0] integ_sum;
   logic signed [25:0] alim_pos;
   logic signed [25:0] alim_neg;
   logic signed [25:0] integ_clamped;

   // compute path
   logic [31:0]        sum_mag;
   logic [7:0]         pgain_mag;
   logic [7:0]         igain_mag;
   logic [24:0]        integ_mag;
   logic signed [24:0] pprod;
   logic signed [24:0] trim_val;
   logic signed [24:0] pval;
   logic signed [26:0] pval_ext;
   logic signed [32:0] iprod;
   logic signed [27:0] iprod_sh;
   logic signed [27:0] ilim_pos;
   logic signed [27:0] ilim_neg;
   logic signed [27:0] total;
   logic signed [27:0] total_sh;
   logic signed [15:0] drive;

   grp_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   grp_serial_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // ---------------- arithmetic ----------------
   assign stick_ext    = {req_item.stick_value[15], req_item.stick_value};
   assign stick_sh     = 3'd6 - cfg.stick_rate;
   assign stick_asr    = stick_ext >>> stick_sh;
   assign stick_scaled = (cfg.stick_rate == 3'd7) ? {req_item.stick_value, 1'b0} : stick_asr;
   assign filter_on    = (cfg.filter_divisor > 8'd1);

   assign fprod    = sign_ff ? -{1'b0, mul_rsp.product[31:0]} : {1'b0, mul_rsp.product[31:0]};
   assign fsum     = fprod + {{9{gyro_ff[15]}}, gyro_ff, 8'h00};
   assign fsum_mag = fsum[32] ? -fsum : fsum;
   assign fquo     = div_rsp.quotient[23:0];

   // truncate toward zero: bias negative values before the shift
   assign smooth_bias = smooth_ff + (smooth_ff[23] ? 24'sd255 : 24'sd0);
   assign gyro_int    = smooth_bias[23:8];
   assign rate_err    = {{2{gyro_int[15]}}, gyro_int} + {stick_ff[16], stick_ff};
   assign rate_neg    = -rate_err;
   assign smooth_mag  = smooth_ff[23] ? -smooth_ff : smooth_ff;

   assign x_mag         = mul_rsp.product[PERIOD_FRAC+21:PERIOD_FRAC];
   assign x_val         = sign_ff ? -{4'b0000, x_mag} : {4'b0000, x_mag};
   assign integ_sum     = {integ_ff[24], integ_ff} + x_val;
   assign alim_pos      = {2'b00, cfg.accum_limit};
   assign alim_neg      = -alim_pos;
   assign integ_clamped = (integ_sum > alim_pos) ? alim_pos :
                          (integ_sum < alim_neg) ? alim_neg : integ_sum;

   assign sum_mag   = sum_ff[31] ? -sum_ff : sum_ff;
   assign pgain_mag = cfg.prop_gain[7] ? -cfg.prop_gain : cfg.prop_gain;
   assign igain_mag = cfg.integ_gain[7] ? -cfg.integ_gain : cfg.integ_gain;
   assign integ_mag = integ_ff[24] ? -integ_ff : integ_ff;

   assign pprod    = sign_ff ? -{2'b00, mul_rsp.product[22:0]} : {2'b00, mul_rsp.product[22:0]};
   assign trim_val = {{(25-8-TRIM_SHIFT){cfg.trim_offset[7]}}, cfg.trim_offset,
                      {TRIM_SHIFT{1'b0}}};
   assign pval     = pprod + trim_val;
   assign pval_ext = {{2{pval[24]}}, pval};

   assign iprod    = sign_ff ? -{2'b00, mul_rsp.product[30:0]} : {2'b00, mul_rsp.product[30:0]};
   assign iprod_sh = iprod[32:I_SHIFT];
   assign ilim_pos = {8'h00, cfg.integ_out_limit};
   assign ilim_neg = -ilim_pos;

   assign total    = {pterm_ff[26], pterm_ff} + {{7{iterm_ff[20]}}, iterm_ff};
   assign total_sh = total >>> OUT_SHIFT;
   assign drive    = (total_sh > 28'sd32767)  ? 16'sh7fff :
                     (total_sh < -28'sd32768) ? 16'sh8000 : total_sh[15:0];

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_item.kind == KIND_COMPUTE) begin
                  state_in = (count_ff == 16'd0) ? S_P_MUL : S_A_DIV;
               end else begin
                  state_in = filter_on ? S_F_MUL : S_R_MUL1;
               end
            end
         end
         S_F_MUL:   state_in = S_F_MULW;
         S_F_MULW:  if (mul_rsp.done) state_in = S_F_ADD;
         S_F_ADD:   state_in = S_F_DIV;
         S_F_DIV:   state_in = S_F_DIVW;
         S_F_DIVW:  if (div_rsp.done) state_in = S_R_MUL1;
         S_R_MUL1:  state_in = S_R_MUL1W;
         S_R_MUL1W: if (mul_rsp.done) state_in = S_R_MUL2;
         S_R_MUL2:  state_in = S_R_MUL2W;
         S_R_MUL2W: if (mul_rsp.done) state_in = S_INTEG;
         S_INTEG:   state_in = S_IDLE;
         S_A_DIV:   state_in = S_A_DIVW;
         S_A_DIVW:  if (div_rsp.done) state_in = S_P_MUL;
         S_P_MUL:   state_in = S_P_MULW;
         S_P_MULW:  if (mul_rsp.done) state_in = S_P_SUM;
         S_P_SUM:   state_in = S_I_MUL;
         S_I_MUL:   state_in = S_I_MULW;
         S_I_MULW:  if (mul_rsp.done) state_in = S_I_CLAMP;
         S_I_CLAMP: state_in = S_TOTAL;
         S_TOTAL:   if (res_free) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // ---------------- unit launches and result ----------------
   always_comb begin
      mul_req  = '0;
      div_req  = '0;
      res_load = 1'b0;
      case (state_ff)
         S_F_MUL: begin
            mul_req.start  = 1'b1;
            mul_req.mcand  = {9'd0, smooth_mag};
            mul_req.mplier = {8'd0, cfg.filter_divisor - 8'd1};
         end
         S_F_DIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = work_ff;
            div_req.divisor  = {8'd0, cfg.filter_divisor};
         end
         S_R_MUL1: begin
            mul_req.start  = 1'b1;
            mul_req.mcand  = {16'd0, rate_err[17] ? rate_neg[16:0] : rate_err[16:0]};
            mul_req.mplier = period_ff;
         end
         S_R_MUL2: begin
            mul_req.start  = 1'b1;
            mul_req.mcand  = mul_rsp.product[MUL_A_W-1:0];
            mul_req.mplier = PERIOD_RECIP;
         end
         S_A_DIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = {1'b0, sum_mag};
            div_req.divisor  = count_ff;
         end
         S_P_MUL: begin
            mul_req.start  = 1'b1;
            mul_req.mcand  = work_ff;
            mul_req.mplier = {8'd0, pgain_mag};
         end
         S_I_MUL: begin
            mul_req.start  = 1'b1;
            mul_req.mcand  = {9'd0, integ_mag[23:0]};
            mul_req.mplier = {8'd0, igain_mag};
         end
         S_TOTAL: begin
            res_load = res_free;
         end
         default: begin
         end
      endcase
   end

   assign busy                   = (state_ff != S_IDLE);
   assign res_item.drive_value   = drive;
   assign res_item.integ_limited = hit_ff;

   // ---------------- datapath registers ----------------
   always_comb begin
      gyro_in   = gyro_ff;
      stick_in  = stick_ff;
      period_in = period_ff;
      smooth_in = smooth_ff;
      integ_in  = integ_ff;
      sum_in    = sum_ff;
      count_in  = count_ff;
      sign_in   = sign_ff;
      work_in   = work_ff;
      pterm_in  = pterm_ff;
      iterm_in  = iterm_ff;
      hit_in    = hit_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               gyro_in   = req_item.gyro_sample;
               stick_in  = stick_scaled;
               period_in = req_item.loop_period;
               if (req_item.kind == KIND_SAMPLE && !filter_on) begin
                  smooth_in = {req_item.gyro_sample, 8'h00};
               end
               // no samples: the average is zero
               work_in = '0;
               sign_in = 1'b0;
            end
         end
         S_F_MUL: sign_in = smooth_ff[23];
         S_F_ADD: begin
            work_in = fsum_mag;
            sign_in = fsum[32];
         end
         S_F_DIVW: begin
            if (div_rsp.done) begin
               smooth_in = sign_ff ? -fquo : fquo;
            end
         end
         S_R_MUL1: sign_in = rate_err[17];
         S_INTEG: begin
            integ_in = integ_clamped[24:0];
            if (count_ff != 16'hffff) begin
               sum_in   = sum_ff + {{16{gyro_int[15]}}, gyro_int};
               count_in = count_ff + 16'd1;
            end
         end
         S_A_DIV: begin
            sign_in  = sum_ff[31];
            sum_in   = '0;
            count_in = '0;
         end
         S_A_DIVW: begin
            if (div_rsp.done) begin
               work_in = div_rsp.quotient;
            end
         end
         S_P_MUL: sign_in = sign_ff ^ cfg.prop_gain[7];
         S_P_SUM: pterm_in = pval_ext + (pval_ext <<< 1);
         S_I_MUL: sign_in = integ_ff[24] ^ cfg.integ_gain[7];
         S_I_CLAMP: begin
            if (iprod_sh > ilim_pos) begin
               iterm_in = ilim_pos[20:0];
               hit_in   = 1'b1;
            end else if (iprod_sh < ilim_neg) begin
               iterm_in = ilim_neg[20:0];
               hit_in   = 1'b1;
            end else begin
               iterm_in = iprod_sh[20:0];
               hit_in   = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         smooth_ff <= '0;
         integ_ff  <= '0;
         sum_ff    <= '0;
         count_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         smooth_ff <= smooth_in;
         integ_ff  <= integ_in;
         sum_ff    <= sum_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      gyro_ff   <= gyro_in;
      stick_ff  <= stick_in;
      period_ff <= period_in;
      sign_ff   <= sign_in;
      work_ff   <= work_in;
      pterm_ff  <= pterm_in;
      iterm_ff  <= iterm_in;
      hit_ff    <= hit_in;
   end

endmodule

`default_nettype wire

[sv/gyro_rate_pi_axis.sv]
// ----------------------------------------------------------------------------
// gyro_rate_pi_axis
// One axis and profile of a gyro rate PI loop with integrator clamp,
// built around a bit-serial multiplier and a bit-serial divider.
// ----------------------------------------------------------------------------
//  channel  signals                        moves
//  req      req_valid req_stall req_data   sample or compute transaction
//  rsp      rsp_valid rsp_stall rsp_data   drive value and clamp flag
//  csr      csr_valid csr_ready csr_index  register write, index and data
//           csr_wdata
//
//  A transaction is taken only while the sequencer is idle; the serial
//  multiplier and divider set the time. A sample runs a filter multiply
//  and divide when the filter is on, then two multiplies; a compute runs
//  an average divide when samples were summed, then two multiplies.
//  Reset clears the configuration to its defaults and the loop state to zero.
//  A result waiting in the output register behind rsp_stall does not hold
//  off the next request; a second compute waits for the register to free.
// ----------------------------------------------------------------------------
`default_nettype none

module gyro_rate_pi_axis (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  grp_pkg::grp_req_type          req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output grp_pkg::grp_rsp_type          rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [2:0]                    csr_index,
   input  logic [grp_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import grp_pkg::*;

   grp_cfg_type cfg_ff, cfg_in;
   logic        rsp_valid_ff, rsp_valid_in;
   grp_rsp_type rsp_data_ff, rsp_data_in;
   logic        busy;
   logic        req_take;
   logic        res_free;
   logic        res_load;
   grp_rsp_type res_item;

   assign csr_ready = 1'b1;
   assign req_stall = busy;
   assign req_take  = req_valid & ~busy;
   assign res_free  = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_STICK_RATE:      cfg_in.stick_rate      = csr_wdata[2:0];
            CSR_FILTER_DIVISOR:  cfg_in.filter_divisor  = csr_wdata[7:0];
            CSR_PROP_GAIN:       cfg_in.prop_gain       = csr_wdata[7:0];
            CSR_INTEG_GAIN:      cfg_in.integ_gain      = csr_wdata[7:0];
            CSR_ACCUM_LIMIT:     cfg_in.accum_limit     = csr_wdata[23:0];
            CSR_INTEG_OUT_LIMIT: cfg_in.integ_out_limit = csr_wdata[19:0];
            CSR_TRIM_OFFSET:     cfg_in.trim_offset     = csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stick_rate      <= 3'd4;
         cfg_ff.filter_divisor  <= 8'd1;
         cfg_ff.prop_gain       <= '0;
         cfg_ff.integ_gain      <= '0;
         cfg_ff.accum_limit     <= 24'hffffff;
         cfg_ff.integ_out_limit <= 20'hfffff;
         cfg_ff.trim_offset     <= '0;
         rsp_valid_ff           <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   grp_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_take (req_take),
      .req_item (req_data),
      .res_free (res_free),
      .busy     (busy),
      .res_load (res_load),
      .res_item (res_item)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
